// ===== design/bplru_pkg.sv =====
// Shared types and constants of the buffer pool LRU frame directory.
package bplru_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF = 32;
	localparam int TABLE_BITS_DEF = 4;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic ST_OK = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	typedef struct packed {
		logic key_eq;
		logic rank_lt;
		logic rank_gt;
	} cmp_res_t;

endpackage

// ===== design/buffer_pool_lru_pin_replacer_top.sv =====
// Top level of the buffer pool frame directory with LRU replacement and pinning.
// A release item goes from S_IDLE to S_RESP and from there into the output register.
// An acquire scans all frames once in S_SCAN (one RAM read per cycle), then decides in S_DECIDE.
// A fill of a never-used frame, or a refusal, then goes straight to S_RESP.
// A hit or an eviction adds a rank update pass over the rank RAM in S_TOUCH before S_RESP.
// One item at a time; a result waits in S_RESP while the output register holds an unread one.
// Reset clears the valid, pin and dirty bits and the fill count at once; the RAMs are not cleared.
module buffer_pool_lru_pin_replacer_top #(
	parameter int FRAMES = bplru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = bplru_pkg::PAGE_BITS_DEF,
	parameter int TABLE_BITS = bplru_pkg::TABLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [TABLE_BITS-1:0]     table_num,
	input  logic [PAGE_BITS-1:0]      page_number,
	input  logic [$clog2(FRAMES)-1:0] release_frame,
	input  logic                      set_dirty,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [$clog2(FRAMES)-1:0] frame_index,
	output logic                      hit,
	output logic                      writeback,
	output logic [TABLE_BITS-1:0]     victim_table,
	output logic [PAGE_BITS-1:0]      victim_page,
	output logic                      status
);

	import bplru_pkg::*;

	localparam int IW = $clog2(FRAMES);
	localparam int CW = IW + 1;
	localparam int KW = TABLE_BITS + PAGE_BITS;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_TOUCH  = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q;

	logic [CW-1:0] addr_q;
	logic rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [KW-1:0] req_key_q;
	logic [FRAMES-1:0] valid_q;
	logic [FRAMES-1:0] pinned_q;
	logic [FRAMES-1:0] dirty_q;
	logic [CW-1:0] frames_used_q;
	logic found_q;
	logic [IW-1:0] hit_f_q;
	logic [IW-1:0] hit_rank_q;
	logic have_q;
	logic [IW-1:0] vic_f_q;
	logic [IW-1:0] vic_rank_q;
	logic [KW-1:0] vic_key_q;
	logic [IW-1:0] tgt_f_q;
	logic [IW-1:0] tgt_r_q;
	logic op_q;
	logic [IW-1:0] res_frame_q;
	logic res_hit_q;
	logic res_wb_q;
	logic [KW-1:0] res_vkey_q;
	logic res_status_q;
	logic out_valid_q;
	logic [IW-1:0] out_frame_q;
	logic out_hit_q;
	logic out_wb_q;
	logic [KW-1:0] out_vkey_q;
	logic out_status_q;

	logic key_we;
	logic [IW-1:0] key_waddr;
	logic [KW-1:0] key_wdata;
	logic [KW-1:0] key_rdata;
	logic rank_we;
	logic [IW-1:0] rank_waddr;
	logic [IW-1:0] rank_wdata;
	logic [IW-1:0] rank_rdata;
	logic [IW-1:0] rank_ref;
	cmp_res_t cmp;
	logic [CW-1:0] fu_m1;
	logic last_rd;
	logic issue;
	logic rel_ok;
	logic out_load;
	logic fill_ok;

	assign in_ready = (state_q == S_IDLE);
	assign fu_m1 = frames_used_q - CW'(1);
	assign last_rd = rd_vld_s1 && (rd_idx_s1 == IW'(FRAMES - 1));
	assign issue = (addr_q < CW'(FRAMES));
	assign rel_ok = ({1'b0, release_frame} < CW'(FRAMES)) && valid_q[release_frame];
	assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign fill_ok = (frames_used_q < CW'(FRAMES));
	assign rank_ref = (state_q == S_TOUCH) ? tgt_r_q : vic_rank_q;

	bplru_ram #(.WIDTH(KW), .DEPTH(FRAMES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (addr_q[IW-1:0]),
		.rdata (key_rdata)
	);

	bplru_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (rank_wdata),
		.raddr (addr_q[IW-1:0]),
		.rdata (rank_rdata)
	);

	bplru_cmp #(.KW(KW), .RW(IW)) u_cmp (
		.key_a  (key_rdata),
		.key_b  (req_key_q),
		.rank_a (rank_rdata),
		.rank_b (rank_ref),
		.res    (cmp)
	);

	always_comb begin
		key_we = 1'b0;
		key_waddr = vic_f_q;
		key_wdata = req_key_q;
		rank_we = 1'b0;
		rank_waddr = rd_idx_s1;
		rank_wdata = rank_rdata - IW'(1);
		if (state_q == S_DECIDE && !found_q) begin
			if (fill_ok) begin
				key_we = 1'b1;
				key_waddr = frames_used_q[IW-1:0];
				rank_we = 1'b1;
				rank_waddr = frames_used_q[IW-1:0];
				rank_wdata = frames_used_q[IW-1:0];
			end else if (have_q) begin
				key_we = 1'b1;
			end
		end else if (state_q == S_TOUCH && rd_vld_s1) begin
			if (rd_idx_s1 == tgt_f_q) begin
				rank_we = 1'b1;
				rank_wdata = fu_m1[IW-1:0];
			end else if (valid_q[rd_idx_s1] && cmp.rank_gt) begin
				rank_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			pinned_q <= '0;
			dirty_q <= '0;
			frames_used_q <= '0;
			rd_vld_s1 <= 1'b0;
			addr_q <= '0;
			found_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						req_key_q <= {table_num, page_number};
						res_frame_q <= '0;
						res_hit_q <= 1'b0;
						res_wb_q <= 1'b0;
						res_vkey_q <= '0;
						res_status_q <= ST_OK;
						found_q <= 1'b0;
						have_q <= 1'b0;
						addr_q <= '0;
						if (op == OP_RELEASE) begin
							res_frame_q <= release_frame;
							if (rel_ok) begin
								pinned_q[release_frame] <= 1'b0;
								if (set_dirty) begin
									dirty_q[release_frame] <= 1'b1;
								end
							end else begin
								res_status_q <= ST_REFUSED;
							end
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= addr_q[IW-1:0];
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end
					if (rd_vld_s1 && valid_q[rd_idx_s1]) begin
						if (cmp.key_eq && !found_q) begin
							found_q <= 1'b1;
							hit_f_q <= rd_idx_s1;
							hit_rank_q <= rank_rdata;
						end
						if (!pinned_q[rd_idx_s1] && (!have_q || cmp.rank_lt)) begin
							have_q <= 1'b1;
							vic_f_q <= rd_idx_s1;
							vic_rank_q <= rank_rdata;
							vic_key_q <= key_rdata;
						end
					end
					if (last_rd) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					addr_q <= '0;
					if (found_q) begin
						pinned_q[hit_f_q] <= 1'b1;
						res_frame_q <= hit_f_q;
						res_hit_q <= 1'b1;
						tgt_f_q <= hit_f_q;
						tgt_r_q <= hit_rank_q;
						state_q <= S_TOUCH;
					end else if (fill_ok) begin
						valid_q[frames_used_q[IW-1:0]] <= 1'b1;
						pinned_q[frames_used_q[IW-1:0]] <= 1'b1;
						dirty_q[frames_used_q[IW-1:0]] <= 1'b0;
						frames_used_q <= frames_used_q + CW'(1);
						res_frame_q <= frames_used_q[IW-1:0];
						state_q <= S_RESP;
					end else if (have_q) begin
						res_wb_q <= dirty_q[vic_f_q];
						res_vkey_q <= vic_key_q;
						pinned_q[vic_f_q] <= 1'b1;
						dirty_q[vic_f_q] <= 1'b0;
						res_frame_q <= vic_f_q;
						tgt_f_q <= vic_f_q;
						tgt_r_q <= vic_rank_q;
						state_q <= S_TOUCH;
					end else begin
						res_status_q <= ST_REFUSED;
						state_q <= S_RESP;
					end
				end
				S_TOUCH: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= addr_q[IW-1:0];
					if (issue) begin
						addr_q <= addr_q + CW'(1);
					end
					if (last_rd) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_frame_q <= res_frame_q;
			out_hit_q <= res_hit_q;
			out_wb_q <= res_wb_q;
			out_vkey_q <= res_vkey_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_index = out_frame_q;
	assign hit = out_hit_q;
	assign writeback = out_wb_q;
	assign victim_table = out_vkey_q[KW-1:PAGE_BITS];
	assign victim_page = out_vkey_q[PAGE_BITS-1:0];
	assign status = out_status_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_used_q <= CW'(FRAMES))
		else $error("Fill count exceeds the number of frames.");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_hit_q |-> !out_wb_q && (out_status_q == ST_OK))
		else $error("A hit result reports a writeback or a refusal.");

	a_pinned_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (op_q == OP_ACQUIRE) && (res_status_q == ST_OK)
		|-> pinned_q[res_frame_q] && valid_q[res_frame_q])
		else $error("A granted frame is not valid and pinned.");

	a_read_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN) || (state_q == S_TOUCH))
		else $error("RAM read data is pending outside a frame pass.");

endmodule

// ===== design/bplru_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bplru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/bplru_cmp.sv =====
// Shared compare unit: key match and recency rank ordering of one frame entry.
module bplru_cmp #(
	parameter int KW = 36,
	parameter int RW = 4
) (
	input  logic [KW-1:0]      key_a,
	input  logic [KW-1:0]      key_b,
	input  logic [RW-1:0]      rank_a,
	input  logic [RW-1:0]      rank_b,
	output bplru_pkg::cmp_res_t res
);

	import bplru_pkg::*;

	always_comb begin
		res.key_eq = (key_a == key_b);
		res.rank_lt = (rank_a < rank_b);
		res.rank_gt = (rank_a > rank_b);
	end

endmodule

// ===== tb/sv/tb_buffer_pool_lru_pin_replacer_top.sv =====
// Self-checking testbench for the buffer pool frame directory with LRU replacement and pinning.
module tb_buffer_pool_lru_pin_replacer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bplru_pkg::*;

	localparam int NF = FRAMES_DEF;
	localparam int IW = $clog2(NF);
	localparam int PW = PAGE_BITS_DEF;
	localparam int TW = TABLE_BITS_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int POOL_KEYS = 24;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 2 * NF + 16;

	typedef struct packed {
		logic          op;
		logic [TW-1:0] tbl_id;
		logic [PW-1:0] page_no;
		logic [IW-1:0] rel_frame;
		logic          mark_dirty;
	} request_t;

	typedef struct packed {
		logic [IW-1:0] frame;
		logic          was_hit;
		logic          wb;
		logic [TW-1:0] vtbl;
		logic [PW-1:0] vpage;
		logic          st;
	} grant_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic          op = OP_ACQUIRE;
	logic [TW-1:0] table_num = '0;
	logic [PW-1:0] page_number = '0;
	logic [IW-1:0] release_frame = '0;
	logic          set_dirty = 1'b0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [IW-1:0] frame_index;
	logic          hit;
	logic          writeback;
	logic [TW-1:0] victim_table;
	logic [PW-1:0] victim_page;
	logic          status;

	request_t request_queue[$];
	grant_t   awaited_grants[$];
	request_t cur_req;
	grant_t   want;
	logic     nxt_valid;

	bit            dir_valid[NF];
	bit [TW-1:0]   dir_tbl[NF];
	bit [PW-1:0]   dir_page[NF];
	bit            dir_pinned[NF];
	bit            dir_dirty[NF];
	int            dir_rank[NF];
	int            used_frames = 0;

	int burst_left = 1;
	int gap_left = 0;
	int rx_cyc = 0;
	int idle_cycles = 0;
	int mismatches = 0;
	int checked = 0;
	int n_hits = 0, n_fills = 0, n_evictions = 0, n_writebacks = 0;
	int n_refused = 0, n_releases = 0;

	buffer_pool_lru_pin_replacer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.table_num    (table_num),
		.page_number  (page_number),
		.release_frame(release_frame),
		.set_dirty    (set_dirty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_index  (frame_index),
		.hit          (hit),
		.writeback    (writeback),
		.victim_table (victim_table),
		.victim_page  (victim_page),
		.status       (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic request_t make_acquire(input logic [TW-1:0] t, input logic [PW-1:0] p);
		request_t rq;
		rq.op = OP_ACQUIRE;
		rq.tbl_id = t;
		rq.page_no = p;
		rq.rel_frame = IW'($urandom_range(0, NF - 1));
		rq.mark_dirty = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	function automatic request_t make_release(input int f, input logic d);
		request_t rq;
		rq.op = OP_RELEASE;
		rq.tbl_id = TW'($urandom_range(0, (1 << TW) - 1));
		rq.page_no = $urandom();
		rq.rel_frame = IW'(f);
		rq.mark_dirty = d;
		return rq;
	endfunction

	task automatic report_mismatch(input string what, input logic [PW-1:0] got,
			input logic [PW-1:0] exp_val);
		$display("mismatch on %s at result %0d: got %h, expected %h",
			what, checked, got, exp_val);
		mismatches++;
	endtask

	// Moves frame f to the most recent position among the filled frames.
	task automatic promote_frame(input int f);
		int i;
		int r0;
		r0 = dir_rank[f];
		for (i = 0; i < NF; i++) begin
			if (dir_valid[i] && dir_rank[i] > r0)
				dir_rank[i]--;
		end
		dir_rank[f] = used_frames - 1;
	endtask

	task automatic apply_to_directory(input request_t rq);
		grant_t g;
		int i;
		int f;
		bit found;
		bit have;
		g = '0;
		f = 0;
		found = 0;
		have = 0;
		if (rq.op == OP_RELEASE) begin
			n_releases++;
			g.frame = rq.rel_frame;
			if (int'(rq.rel_frame) < NF && dir_valid[rq.rel_frame]) begin
				dir_pinned[rq.rel_frame] = 0;
				if (rq.mark_dirty)
					dir_dirty[rq.rel_frame] = 1;
			end else begin
				g.st = ST_REFUSED;
			end
		end else begin
			for (i = 0; i < NF; i++) begin
				if (!found && dir_valid[i] && dir_tbl[i] == rq.tbl_id
						&& dir_page[i] == rq.page_no) begin
					found = 1;
					f = i;
				end
			end
			if (found) begin
				dir_pinned[f] = 1;
				promote_frame(f);
				g.frame = IW'(f);
				g.was_hit = 1'b1;
				n_hits++;
			end else if (used_frames < NF) begin
				f = used_frames;
				dir_valid[f] = 1;
				dir_tbl[f] = rq.tbl_id;
				dir_page[f] = rq.page_no;
				dir_pinned[f] = 1;
				dir_dirty[f] = 0;
				dir_rank[f] = used_frames;
				used_frames++;
				g.frame = IW'(f);
				n_fills++;
			end else begin
				for (i = 0; i < NF; i++) begin
					if (dir_valid[i] && !dir_pinned[i] && (!have || dir_rank[i] < dir_rank[f])) begin
						have = 1;
						f = i;
					end
				end
				if (!have) begin
					g.st = ST_REFUSED;
					n_refused++;
				end else begin
					g.wb = dir_dirty[f];
					g.vtbl = dir_tbl[f];
					g.vpage = dir_page[f];
					dir_tbl[f] = rq.tbl_id;
					dir_page[f] = rq.page_no;
					dir_pinned[f] = 1;
					dir_dirty[f] = 0;
					promote_frame(f);
					g.frame = IW'(f);
					n_evictions++;
					if (g.wb)
						n_writebacks++;
				end
			end
		end
		awaited_grants.push_back(g);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				apply_to_directory(cur_req);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_queue.size() != 0) begin
					cur_req = request_queue.pop_front();
					op <= cur_req.op;
					table_num <= cur_req.tbl_id;
					page_number <= cur_req.page_no;
					release_frame <= cur_req.rel_frame;
					set_dirty <= cur_req.mark_dirty;
					nxt_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cyc++;
			case ((rx_cyc / 256) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ((rx_cyc % 32) < 20);
				default: out_ready <= ((rx_cyc % 64) >= 40);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_grants.size() == 0) begin
				report_mismatch("result with no request outstanding", PW'(frame_index), '0);
			end else begin
				want = awaited_grants.pop_front();
				if (frame_index !== want.frame)
					report_mismatch("frame_index", PW'(frame_index), PW'(want.frame));
				if (hit !== want.was_hit)
					report_mismatch("hit", PW'(hit), PW'(want.was_hit));
				if (writeback !== want.wb)
					report_mismatch("writeback", PW'(writeback), PW'(want.wb));
				if (victim_table !== want.vtbl)
					report_mismatch("victim_table", PW'(victim_table), PW'(want.vtbl));
				if (victim_page !== want.vpage)
					report_mismatch("victim_page", victim_page, want.vpage);
				if (status !== want.st)
					report_mismatch("status", PW'(status), PW'(want.st));
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles with %0d results outstanding",
					idle_cycles, awaited_grants.size());
				$display("[buffer_pool_lru_pin_replacer_top] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [TW-1:0] pool_tbl[POOL_KEYS];
		logic [PW-1:0] pool_page[POOL_KEYS];
		int pinned_list[$];
		int i;
		int k;
		int f;
		arst_n = 1'b0;

		for (k = 0; k < POOL_KEYS; k++) begin
			if (k < 6) begin
				pool_tbl[k] = TW'(k * 3);
				pool_page[k] = 32'(k * 3) * 32'h1111_1111;
			end else begin
				pool_tbl[k] = TW'($urandom_range(0, (1 << TW) - 1));
				case ($urandom_range(0, 3))
					0: pool_page[k] = $urandom_range(0, 7);
					1: pool_page[k] = pool_page[k - 1];
					default: pool_page[k] = $urandom();
				endcase
			end
		end

		// Releases of frames never filled, then every frame filled with the
		// extreme keys at both ends.
		request_queue.push_back(make_release(3, 1'b1));
		request_queue.push_back(make_acquire(TW'(0), PW'(0)));
		request_queue.push_back(make_release(NF - 1, 1'b0));
		for (k = 1; k < NF; k++)
			request_queue.push_back(make_acquire(TW'(k), 32'(k) * 32'h1111_1111));
		// A hit, a refusal with every frame pinned, dirty and repeated releases,
		// a hit on a dirty frame, and evictions that need a writeback.
		request_queue.push_back(make_acquire(TW'(0), PW'(0)));
		request_queue.push_back(make_acquire(TW'(9), 32'h0000_0001));
		request_queue.push_back(make_release(2, 1'b1));
		request_queue.push_back(make_release(2, 1'b0));
		request_queue.push_back(make_release(7, 1'b1));
		request_queue.push_back(make_acquire(TW'(7), 32'h7777_7777));
		request_queue.push_back(make_acquire(TW'(3), 32'hDEAD_BEEF));
		request_queue.push_back(make_release(7, 1'b0));
		request_queue.push_back(make_acquire(TW'(12), 32'h8000_0000));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			while (request_queue.size() >= 2)
				@(negedge clk);
			if ($urandom_range(0, 99) < 40) begin
				pinned_list.delete();
				for (i = 0; i < NF; i++) begin
					if (dir_pinned[i])
						pinned_list.push_back(i);
				end
				if (pinned_list.size() != 0 && $urandom_range(0, 3) != 0)
					f = pinned_list[$urandom_range(0, pinned_list.size() - 1)];
				else
					f = $urandom_range(0, NF - 1);
				request_queue.push_back(make_release(f, 1'($urandom_range(0, 1))));
			end else if ($urandom_range(0, 99) < 85) begin
				f = $urandom_range(0, POOL_KEYS - 1);
				request_queue.push_back(make_acquire(pool_tbl[f], pool_page[f]));
			end else begin
				request_queue.push_back(make_acquire(TW'($urandom_range(0, (1 << TW) - 1)),
					$urandom()));
			end
		end

		while (request_queue.size() != 0 || in_valid)
			@(negedge clk);
		while (awaited_grants.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_grants.size() != 0)
			report_mismatch("results never delivered", PW'(awaited_grants.size()), '0);

		$display("Ran %0d hits, %0d fills, %0d evictions (%0d with writeback), %0d refused acquires.",
			n_hits, n_fills, n_evictions, n_writebacks, n_refused);
		$display("Ran %0d releases; %0d results checked, %0d mismatches.",
			n_releases, checked, mismatches);
		if (mismatches == 0)
			$display("[buffer_pool_lru_pin_replacer_top] OK");
		else
			$display("[buffer_pool_lru_pin_replacer_top] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/bplru_pkg.sv
design/bplru_ram.sv
design/bplru_cmp.sv
design/buffer_pool_lru_pin_replacer_top.sv
tb/sv/tb_buffer_pool_lru_pin_replacer_top.sv
